### src/svia_pkg.sv
// Package for the stack VM integer ALU: operation codes, class codes and payload types.
package svia_pkg;

    localparam int DEFAULT_DATA_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;
    localparam int OP_WIDTH = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD    = 5'd0,
        OP_SUB    = 5'd1,
        OP_AND    = 5'd2,
        OP_OR     = 5'd3,
        OP_XOR    = 5'd4,
        OP_LSH    = 5'd5,
        OP_RSH    = 5'd6,
        OP_MUL    = 5'd7,
        OP_DIV    = 5'd8,
        OP_MOD    = 5'd9,
        OP_EQ     = 5'd10,
        OP_NE     = 5'd11,
        OP_LT     = 5'd12,
        OP_GT     = 5'd13,
        OP_GE     = 5'd14,
        OP_LE     = 5'd15,
        OP_NOT    = 5'd16,
        OP_COMPL  = 5'd17,
        OP_NEGATE = 5'd18
    } op_t;

    // Operation class decided by the front end.
    typedef enum logic [2:0] {
        CLS_SIMPLE = 3'b001,
        CLS_MUL    = 3'b010,
        CLS_DIV    = 3'b100
    } op_class_t;

    typedef struct packed {
        logic [OP_WIDTH-1:0]           operation;
        logic signed [FIELD_WIDTH-1:0] first_operand;
        logic signed [FIELD_WIDTH-1:0] second_operand;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] result_value;
        logic                          error_code;
    } out_item_t;

endpackage

### src/svia_front.sv
// Front end: accepts items, sign-extends or truncates operands, classifies ops, and queues them.
module svia_front import svia_pkg::*; #(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  q_valid,
    input  logic                  q_pop,
    output logic [OP_WIDTH-1:0]   q_op,
    output op_class_t             q_class,
    output logic [DATA_WIDTH-1:0] q_a,
    output logic [DATA_WIDTH-1:0] q_b
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [OP_WIDTH-1:0]   op_mem [QUEUE_DEPTH];
    op_class_t             cls_mem [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] a_mem [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] b_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push;
    op_class_t        cls;
    logic [DATA_WIDTH-1:0] a_ext, b_ext;

    // Sign-extend or truncate the 32-bit fields to the datapath width.
    always_comb
    begin
        if (DATA_WIDTH >= FIELD_WIDTH)
        begin
            a_ext = DATA_WIDTH'($signed(in_item.first_operand));
            b_ext = DATA_WIDTH'($signed(in_item.second_operand));
        end
        else
        begin
            a_ext = in_item.first_operand[DATA_WIDTH-1:0];
            b_ext = in_item.second_operand[DATA_WIDTH-1:0];
        end
    end

    always_comb
    begin
        unique case (in_item.operation)
            OP_MUL:         cls = CLS_MUL;
            OP_DIV, OP_MOD: cls = CLS_DIV;
            default:        cls = CLS_SIMPLE;
        endcase
    end

    assign in_stall = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_op     = op_mem[rd_ptr_reg];
    assign q_class  = cls_mem[rd_ptr_reg];
    assign q_a      = a_mem[rd_ptr_reg];
    assign q_b      = b_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]  <= in_item.operation;
            cls_mem[wr_ptr_reg] <= cls;
            a_mem[wr_ptr_reg]   <= a_ext;
            b_mem[wr_ptr_reg]   <= b_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (q_pop && q_valid)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop && q_valid);
        end
    end
endmodule

### src/svia_divider.sv
// Pipelined signed divider: one quotient bit per stage, one item per cycle while advance is high.
module svia_divider import svia_pkg::*; #(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  advance,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    input  logic                  want_mod,
    output logic [DATA_WIDTH-1:0] result,
    output logic                  div_zero
);
    localparam int N = DATA_WIDTH;

    logic [N-1:0] rem_reg [N+1];
    logic [N-1:0] quo_reg [N+1];
    logic [N-1:0] dsr_reg [N+1];
    logic         neg_q_reg [N+1];
    logic         neg_r_reg [N+1];
    logic         mod_reg [N+1];
    logic         zero_reg [N+1];
    logic [N-1:0] mag_a, mag_b;

    assign mag_a = dividend[N-1] ? (N'(0) - dividend) : dividend;
    assign mag_b = divisor[N-1]  ? (N'(0) - divisor)  : divisor;

    // Stage 0 holds the magnitudes; quo shifts dividend bits out as remainder builds.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]   <= '0;
            quo_reg[0]   <= mag_a;
            dsr_reg[0]   <= mag_b;
            neg_q_reg[0] <= dividend[N-1] ^ divisor[N-1];
            neg_r_reg[0] <= dividend[N-1];
            mod_reg[0]   <= want_mod;
            zero_reg[0]  <= (divisor == '0);
        end
    end

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [N:0] trial;
        logic [N:0] diff;
        assign trial = {rem_reg[s], quo_reg[s][N-1]};
        assign diff  = trial - {1'b0, dsr_reg[s]};
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[s+1]   <= diff[N] ? trial[N-1:0] : diff[N-1:0];
                quo_reg[s+1]   <= {quo_reg[s][N-2:0], !diff[N]};
                dsr_reg[s+1]   <= dsr_reg[s];
                neg_q_reg[s+1] <= neg_q_reg[s];
                neg_r_reg[s+1] <= neg_r_reg[s];
                mod_reg[s+1]   <= mod_reg[s];
                zero_reg[s+1]  <= zero_reg[s];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[N])
            result = '0;
        else if (mod_reg[N])
            result = neg_r_reg[N] ? (N'(0) - rem_reg[N]) : rem_reg[N];
        else
            result = neg_q_reg[N] ? (N'(0) - quo_reg[N]) : quo_reg[N];
    end
    assign div_zero = zero_reg[N];
endmodule

### src/svia_back.sv
// Back end: lock-step pipeline with ALU, multiplier and divider lanes.
module svia_back import svia_pkg::*; #(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  logic [OP_WIDTH-1:0]   q_op,
    input  op_class_t             q_class,
    input  logic [DATA_WIDTH-1:0] q_a,
    input  logic [DATA_WIDTH-1:0] q_b,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item
);
    localparam int N = DATA_WIDTH;
    localparam int DEPTH = N + 1;   // divider stages set the latency
    localparam int SHW = $clog2(N);
    localparam int MH = (N + 1) / 2;

    logic               vld_reg [DEPTH];
    op_class_t          cls_reg [DEPTH];
    logic [N-1:0]       sres_reg [DEPTH];
    logic [N-1:0]       mlo_reg, mhi_reg, mcross_reg;
    logic [N-1:0]       mul_reg [1:DEPTH-1];
    logic               advance;
    logic [N-1:0]       simple;
    logic [N-1:0]       div_res;
    logic               div_zero;
    logic               shift_ok;
    logic               lt_ab, lt_ba;
    logic [SHW-1:0]     sh;

    // Pipeline moves whenever its last slot is empty or being taken.
    assign advance   = !vld_reg[DEPTH-1] || !out_stall;
    assign q_pop     = advance;
    assign out_valid = vld_reg[DEPTH-1];

    assign shift_ok = !q_b[N-1] && (q_b < N'(N));
    assign sh       = q_b[SHW-1:0];
    assign lt_ab    = $signed(q_a) < $signed(q_b);
    assign lt_ba    = $signed(q_b) < $signed(q_a);

    always_comb
    begin
        unique case (q_op)
            OP_ADD:    simple = q_a + q_b;
            OP_SUB:    simple = q_a - q_b;
            OP_AND:    simple = q_a & q_b;
            OP_OR:     simple = q_a | q_b;
            OP_XOR:    simple = q_a ^ q_b;
            OP_LSH:    simple = shift_ok ? (q_a << sh) : '0;
            OP_RSH:    simple = shift_ok ? N'($signed(q_a) >>> sh) : {N{q_a[N-1]}};
            OP_EQ:     simple = N'(q_a == q_b);
            OP_NE:     simple = N'(q_a != q_b);
            OP_LT:     simple = N'(lt_ab);
            OP_GT:     simple = N'(lt_ba);
            OP_GE:     simple = N'(!lt_ab);
            OP_LE:     simple = N'(!lt_ba);
            OP_NOT:    simple = N'(q_b == '0);
            OP_COMPL:  simple = ~q_b;
            OP_NEGATE: simple = N'(0) - q_b;
            default:   simple = '0;
        endcase
    end

    // Multiplier: low word as three half-width products, summed next stage.
    logic [N-1:0] a_lo, a_hi, b_lo, b_hi;
    assign a_lo = N'(q_a[MH-1:0]);
    assign b_lo = N'(q_b[MH-1:0]);
    assign a_hi = q_a >> MH;
    assign b_hi = q_b >> MH;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mlo_reg    <= N'(a_lo * b_lo);
            mhi_reg    <= N'(a_hi * b_lo);
            mcross_reg <= N'(a_lo * b_hi);
            sres_reg[0] <= simple;
            cls_reg[0]  <= q_class;
            mul_reg[1]  <= mlo_reg + ((mhi_reg + mcross_reg) << MH);
            for (int i = 1; i < DEPTH; i++)
            begin
                sres_reg[i] <= sres_reg[i-1];
                cls_reg[i]  <= cls_reg[i-1];
            end
            for (int i = 2; i < DEPTH; i++)
                mul_reg[i] <= mul_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= q_valid;
            for (int i = 1; i < DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    svia_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .clk      (clk),
        .advance  (advance),
        .dividend (q_a),
        .divisor  (q_b),
        .want_mod (q_op == OP_MOD),
        .result   (div_res),
        .div_zero (div_zero)
    );

    logic [N-1:0] final_res;
    always_comb
    begin
        unique case (cls_reg[DEPTH-1])
            CLS_MUL: final_res = mul_reg[DEPTH-1];
            CLS_DIV: final_res = div_res;
            default: final_res = sres_reg[DEPTH-1];
        endcase
        if (N >= FIELD_WIDTH)
            out_item.result_value = final_res[FIELD_WIDTH-1:0];
        else
            out_item.result_value = FIELD_WIDTH'($signed(final_res));
        out_item.error_code = (cls_reg[DEPTH-1] == CLS_DIV) && div_zero;
    end
endmodule

### src/stack_vm_integer_alu.sv
// Top level of the stack VM integer ALU.
// Usage:
//   Input channel in_valid/in_stall/in_item carries one item: an operation
//   code and two signed 32-bit operands (first = below top, second = top).
//   Output channel out_valid/out_stall/out_item returns one result item per
//   input item, in order: result word and the divide-by-zero error flag.
//   An item is taken on a rising edge with valid high and stall low.
// Pipeline: each accepted item waits in the front queue, then moves through
//   the DATA_WIDTH + 1 back-end stages. The length is set by the divider,
//   which retires one quotient bit per stage; every class runs through the
//   same lock-step pipeline so order is kept.
// Throughput: one item per cycle, back to back, while out_stall stays low.
// Stall: when out_stall holds with a result waiting, the back pipeline freezes;
//   the front queue (two entries) keeps taking items until full, then raises in_stall.
// Reset: rst_n asynchronously empties the queue and clears all valid bits;
//   no item is in flight afterward.
module stack_vm_integer_alu import svia_pkg::*; #(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);
    logic                  q_valid, q_pop;
    logic [OP_WIDTH-1:0]   q_op;
    op_class_t             q_class;
    logic [DATA_WIDTH-1:0] q_a, q_b;

    // Front: classify and buffer.
    svia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_op     (q_op),
        .q_class  (q_class),
        .q_a      (q_a),
        .q_b      (q_b)
    );

    // Back: execute in a fixed-length pipeline.
    svia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_op      (q_op),
        .q_class   (q_class),
        .q_a       (q_a),
        .q_b       (q_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Divide by zero returns a zero word with the error flag.
    a_err_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.error_code && out_valid |-> out_item.result_value == '0)
        else $error("divide-by-zero result not zero");

    // A stalled result must not vanish.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    // Reset leaves the block empty and ready.
    a_no_stall_after_reset: assert property (@(posedge clk)
        !rst_n |-> !in_stall && !out_valid)
        else $error("reset did not empty the block");
endmodule

### tb/tb_stack_vm_integer_alu.sv
// Testbench for the stack VM integer ALU: random and directed operator items checked against a predictor.
module tb_stack_vm_integer_alu;
    import svia_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Results waiting to come back, oldest first, plus the mismatch tally.
    class alu_scoreboard;
        out_item_t pending[$];
        int        errors;

        // Work out the result word for one operator item at 32 bits.
        function out_item_t compute(in_item_t it);
            out_item_t   r;
            logic signed [31:0] a;
            logic signed [31:0] b;
            logic [31:0] ua;
            logic [31:0] ub;
            logic [31:0] q;
            logic        shift_ok;
            a = it.first_operand;
            b = it.second_operand;
            r.result_value = '0;
            r.error_code   = 1'b0;
            shift_ok = (b >= 0) && (b < 32);
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            case (it.operation)
                OP_ADD:    r.result_value = a + b;
                OP_SUB:    r.result_value = a - b;
                OP_AND:    r.result_value = a & b;
                OP_OR:     r.result_value = a | b;
                OP_XOR:    r.result_value = a ^ b;
                OP_LSH:    r.result_value = shift_ok ? (a << b[4:0]) : '0;
                OP_RSH:    r.result_value = shift_ok ? $signed(a >>> b[4:0]) : {32{a[31]}};
                OP_MUL:    r.result_value = a * b;
                OP_DIV, OP_MOD:
                begin
                    if (b == 0)
                    begin
                        r.error_code = 1'b1;
                    end
                    else if (it.operation == OP_DIV)
                    begin
                        q = ua / ub;
                        r.result_value = (a[31] != b[31]) ? -q : q;
                    end
                    else
                    begin
                        q = ua % ub;
                        r.result_value = a[31] ? -q : q;
                    end
                end
                OP_EQ:     r.result_value = (a == b);
                OP_NE:     r.result_value = (a != b);
                OP_LT:     r.result_value = (a < b);
                OP_GT:     r.result_value = (a > b);
                OP_GE:     r.result_value = (a >= b);
                OP_LE:     r.result_value = (a <= b);
                OP_NOT:    r.result_value = (b == 0);
                OP_COMPL:  r.result_value = ~b;
                OP_NEGATE: r.result_value = -b;
                default:   r.result_value = '0;
            endcase
            return r;
        endfunction

        function void note_operator(in_item_t it);
            pending.push_back(compute(it));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing pending");
                return;
            end
            want = pending.pop_front();
            if (got.result_value !== want.result_value)
                report_mismatch($sformatf("result_value got %h want %h",
                                          got.result_value, want.result_value));
            if (got.error_code !== want.error_code)
                report_mismatch($sformatf("error_code got %b want %b",
                                          got.error_code, want.error_code));
        endfunction

        function void report_mismatch(string msg);
            errors++;
            if (errors <= 50)
                $display("MISMATCH @%0t: %s", $time, msg);
        endfunction
    endclass

    localparam int LATENCY   = DEFAULT_DATA_WIDTH + 2;
    localparam int MAX_CYCLES = 200000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    alu_scoreboard board;
    int  cycle_count;
    bit  stall_quiet;   // receiver stops stalling while set

    stack_vm_integer_alu dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    // 20 ns clock.
    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("tb_stack_vm_integer_alu: errors");
            $finish;
        end
    end

    // Result monitor: sample at the edge, compare with the oldest pending item.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_item);
    end

    // Receiver stall pattern: runs of stall and runs of open, with quiet periods.
    initial
    begin
        int run;
        int mode;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(1, 12);
            repeat (run)
            begin
                @(posedge clk);
                if (stall_quiet || mode == 0)
                    out_stall <= 1'b0;
                else if (mode == 1)
                    out_stall <= 1'b1;
                else
                    out_stall <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    // Present one item and hold it until taken. Leaves valid high.
    task automatic send_operator(input logic [4:0] op, input logic [31:0] a,
                                 input logic [31:0] b);
        in_item_t it;
        it.operation      = op;
        it.first_operand  = a;
        it.second_operand = b;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_operator(it);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Random operand biased toward corners.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(0, 40);
            6: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // Wait until every pending result is back, with a hold-off afterward.
    task automatic drain_all();
        in_valid <= 1'b0;
        stall_quiet = 1'b1;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        stall_quiet = 1'b0;
    endtask

    initial
    begin
        logic [31:0] corners[6];
        int burst;
        int op;
        board       = new();
        cycle_count = 0;
        stall_quiet = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        corners     = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0,
                        32'd1, 32'd31};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every opcode on corner values, then the special cases.
        for (int k = 0; k < 19; k++)
            send_operator(k[4:0], corners[k % 6], corners[(k + 3) % 6]);
        send_operator(OP_DIV, 32'h8000_0000, 32'hffff_ffff);   // overflow divide
        send_operator(OP_MOD, 32'h8000_0000, 32'hffff_ffff);
        send_operator(OP_DIV, 32'd7, 32'd0);                   // divide by zero
        send_operator(OP_MOD, -32'd7, 32'd0);
        send_operator(OP_RSH, 32'h8000_0000, 32'd32);          // shift out of range
        send_operator(OP_LSH, 32'hffff_ffff, -32'd1);
        send_operator(5'd31, 32'hffff_ffff, 32'hffff_ffff);    // unused code
        drain_all();

        // Random bursts with gaps; one full drain half way.
        for (int n = 0; n < 650; )
        begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst; j++)
            begin
                op = ($urandom_range(0, 15) == 0) ? $urandom_range(19, 31)
                                                  : $urandom_range(0, 18);
                if ((op == OP_LSH || op == OP_RSH) && $urandom_range(0, 3) != 0)
                    send_operator(op[4:0], pick_operand(), $urandom_range(0, 31));
                else
                    send_operator(op[4:0], pick_operand(), pick_operand());
                n++;
            end
            if (n > 300 && n <= 300 + burst)
                drain_all();
            else
                idle_cycles($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0);
        end
        drain_all();

        if (board.errors == 0)
            $display("tb_stack_vm_integer_alu: clean");
        else
            $display("tb_stack_vm_integer_alu: errors");
        $finish;
    end

endmodule
